// ===== src/gcma_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package gcma_pkg;
	localparam int MaxWidth = 256;
	localparam int AddrW = $clog2(2 * MaxWidth);
	localparam int ColW = 9;
	localparam int RowW = 12;
	localparam int Steps = 13;

	localparam logic [31:0] GradHi = 32'h0007_ffff;
	localparam logic [31:0] GradLo = 32'hfff8_0000;
	localparam logic [31:0] MagSat = 32'h0003_ffff;
	localparam logic [15:0] AngHalf = 16'h3244;
	localparam logic [15:0] AngQuarter = 16'h1922;
	localparam logic [15:0] AngNegQuarter = 16'he6de;
	localparam logic [15:0] AngNegHalf = 16'hcdbc;
	localparam logic [16:0] RoundHalf = 17'h0_8000;

	localparam logic [3:0] RegWidth = 4'h0;
	localparam logic [3:0] RegHeight = 4'h4;

	typedef enum logic [1:0] {
		SPEC_NONE = 2'b00,
		SPEC_VZERO = 2'b01,
		SPEC_HZERO = 2'b10
	} spec_t;

	// per-step CORDIC lane state
	typedef struct packed {
		logic valid;
		logic last;
		logic [31:0] v;
		logic [31:0] h;
		logic [31:0] v0;
		logic [31:0] h0;
		logic [15:0] ang;
		logic [3:0] stop;
		logic done;
		spec_t spec;
	} lane_t;

	function automatic logic [15:0] atan_of(input logic [3:0] i);
		logic [15:0] r;
		begin
			unique case (i)
				4'd0: r = 16'd3217;
				4'd1: r = 16'd1899;
				4'd2: r = 16'd1003;
				4'd3: r = 16'd509;
				4'd4: r = 16'd256;
				4'd5: r = 16'd128;
				4'd6: r = 16'd64;
				4'd7: r = 16'd32;
				4'd8: r = 16'd16;
				4'd9: r = 16'd8;
				4'd10: r = 16'd4;
				4'd11: r = 16'd2;
				4'd12: r = 16'd1;
				default: r = 16'd0;
			endcase
			return r;
		end
	endfunction

	function automatic logic [16:0] gain_of(input logic [3:0] i);
		logic [16:0] r;
		begin
			unique case (i)
				4'd0: r = 17'd46341;
				4'd1: r = 17'd41449;
				4'd2: r = 17'd40211;
				4'd3: r = 17'd39901;
				4'd4: r = 17'd39823;
				4'd5: r = 17'd39803;
				4'd6: r = 17'd39799;
				default: r = 17'd39797;
			endcase
			return r;
		end
	endfunction

	function automatic logic not_pos(input logic [31:0] v);
		return (v == 32'd0) || v[31];
	endfunction

	function automatic logic [31:0] clamp_shift(input logic [31:0] d);
		logic [31:0] c;
		begin
			c = d;
			if (d[31]) begin
				if (d < GradLo) c = GradLo;
			end else if (d > GradHi) begin
				c = GradHi;
			end
			return {c[19:0], 12'd0};
		end
	endfunction
endpackage
`default_nettype wire

// ===== src/gcma_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gcma_ram #(
	parameter int Width = 32,
	parameter int Depth = 512
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(Depth)-1:0] waddr,
	input wire logic [Width-1:0] wdata,
	input wire logic re,
	input wire logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem_q [Depth];

	// write port, registered read port
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== src/gcma_cordic_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gcma_cordic_step import gcma_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire logic [3:0] idx,
	input wire lane_t d,
	output lane_t q
);
	logic [31:0] vs, hs;
	lane_t n;

	// one rotation; hold the lane once the vertical part has reached zero
	always_comb begin
		vs = $signed(d.v) >>> idx;
		hs = $signed(d.h) >>> idx;
		n = d;
		if (d.valid && !d.done && d.spec == SPEC_NONE) begin
			if (not_pos(d.v)) begin
				n.v = d.v + hs;
				n.h = d.h - vs;
				n.ang = d.ang - atan_of(idx);
			end else begin
				n.v = d.v - hs;
				n.h = d.h + vs;
				n.ang = d.ang + atan_of(idx);
			end
			n.stop = idx;
			n.done = (n.v == 32'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) q <= '0;
		else if (en) q <= n;
	end
endmodule
`default_nettype wire

// ===== src/gradient_cordic_magnitude_angle_map.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel | direction | handshake        | payload
// pixel   | in        | valid / stall    | pixel[31:0]
// result  | out       | out_valid / out_stall | grad_magnitude, grad_angle, frame_last
// config  | in        | APB write/read   | frame_width (0x0), frame_height (0x4)
// One pixel per cycle while out_stall is low; results pass through a
// pipeline of line-store read, difference, 13 CORDIC steps, gain multiply
// and output stages. The whole pipeline advances together, so a held
// result stalls the input. arst_n clears positions and valids, sets both
// size registers to 256; the line store is not cleared (written before read).
module gradient_cordic_magnitude_angle_map import gcma_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic valid,
	output logic stall,
	input wire logic [31:0] pixel,
	output logic out_valid,
	input wire logic out_stall,
	output logic [19:0] grad_magnitude,
	output logic [15:0] grad_angle,
	output logic frame_last,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [2:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	logic [ColW-1:0] width_q, col_q;
	logic [RowW-1:0] height_q, row_q;
	logic [ColW-1:0] w_eff;
	logic [RowW-1:0] h_eff;
	logic adv, acc, cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign adv = !(out_valid && out_stall);
	assign stall = !adv;
	assign acc = valid && adv;

	always_comb begin
		w_eff = width_q;
		if (width_q < ColW'(3)) w_eff = ColW'(3);
		if (width_q > ColW'(MaxWidth)) w_eff = ColW'(MaxWidth);
		h_eff = (height_q < RowW'(3)) ? RowW'(3) : height_q;
	end

	// register file read
	always_comb begin
		unique case ({1'b0, paddr})
			RegWidth: prdata = {23'd0, width_q};
			RegHeight: prdata = {20'd0, height_q};
			default: prdata = 32'd0;
		endcase
	end

	// positions; any register write restarts the frame
	logic [ColW-1:0] x;
	logic [RowW-1:0] r;
	logic emit, lastf;
	always_comb begin
		x = (col_q >= w_eff) ? '0 : col_q;
		r = (row_q >= h_eff) ? '0 : row_q;
		emit = r >= RowW'(2) && x >= ColW'(1) && (x + ColW'(2)) <= w_eff;
		lastf = (x + ColW'(2)) == w_eff && (r + RowW'(1)) == h_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= ColW'(256); height_q <= RowW'(256);
			col_q <= '0; row_q <= '0;
		end else if (cfg_wr) begin
			if ({1'b0, paddr} == RegWidth) width_q <= pwdata[ColW-1:0];
			if ({1'b0, paddr} == RegHeight) height_q <= pwdata[RowW-1:0];
			col_q <= '0; row_q <= '0;
		end else if (acc) begin
			if (x + ColW'(1) >= w_eff) begin
				col_q <= '0;
				row_q <= (r + RowW'(1) >= h_eff) ? '0 : r + RowW'(1);
			end else begin
				col_q <= x + ColW'(1);
			end
		end
	end

	// line store in two memories, bank r[0] holds row r.
	// up memory keeps each pixel at its column; side memory keeps, at column x,
	// the pair {P(x+1), P(x-1)} of a row, written once P(x+1) arrives.
	logic [AddrW-1:0] wa, wa_lr, a_up, a_lr;
	logic [31:0] d_up, d_l, d_r, p1_q, p2_q;
	logic [63:0] d_lr;
	logic ren, we_lr;
	assign ren = acc && emit;
	assign wa = {r[0], x[ColW-2:0]};
	assign a_up = {r[0], x[ColW-2:0]};
	assign wa_lr = {r[0], 8'(x - ColW'(1))};
	assign a_lr = {~r[0], x[ColW-2:0]};
	assign we_lr = acc && (x != '0);
	assign d_r = d_lr[63:32];
	assign d_l = d_lr[31:0];

	// keep the two pixels before the current one
	always_ff @(posedge clk) begin
		if (acc) begin
			p1_q <= pixel;
			p2_q <= p1_q;
		end
	end

	gcma_ram #(.Width(32), .Depth(2 * MaxWidth)) u_ram_up (
		.clk(clk), .we(acc), .waddr(wa), .wdata(pixel),
		.re(ren), .raddr(a_up), .rdata(d_up));
	gcma_ram #(.Width(64), .Depth(2 * MaxWidth)) u_ram_lr (
		.clk(clk), .we(we_lr), .waddr(wa_lr), .wdata({pixel, p2_q}),
		.re(ren), .raddr(a_lr), .rdata(d_lr));

	// stage 1: hold current pixel alongside the reads
	logic v_s1, last_s1;
	logic [31:0] cur_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= acc && emit;
	end
	always_ff @(posedge clk) begin
		if (adv) begin cur_s1 <= pixel; last_s1 <= lastf; end
	end

	// stage 2: differences, clamp, fold to the first quadrant
	lane_t l0, l0_n;
	logic [31:0] gh, gv, hp, vp;
	always_comb begin
		gh = clamp_shift(d_r - d_l);
		gv = clamp_shift(cur_s1 - d_up);
		hp = not_pos(gh) ? 32'd0 - gh : gh;
		vp = not_pos(gv) ? 32'd0 - gv : gv;
		l0_n = '0;
		l0_n.valid = v_s1;
		l0_n.last = last_s1;
		l0_n.v = vp;
		l0_n.h = hp;
		l0_n.v0 = gv;
		l0_n.h0 = gh;
		l0_n.spec = (vp == 32'd0) ? SPEC_VZERO :
			(hp == 32'd0) ? SPEC_HZERO : SPEC_NONE;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) l0 <= '0;
		else if (adv) l0 <= l0_n;
	end

	// CORDIC steps
	lane_t lane [Steps+1];
	assign lane[0] = l0;
	for (genvar i = 0; i < Steps; i++) begin : g_step
		gcma_cordic_step u_step (
			.clk(clk), .arst_n(arst_n), .en(adv), .idx(4'(i)), .d(lane[i]),
			.q(lane[i+1]));
	end

	// quadrant fix and gain multiply
	lane_t e;
	logic [15:0] ang_f, ang_s2;
	logic signed [48:0] mul;
	logic [48:0] prod_s2;
	logic [31:0] mag_pass_s2;
	logic v_m, last_m;
	spec_t spec_m;
	assign e = lane[Steps];
	always_comb begin
		ang_f = e.ang;
		unique case (e.spec)
			SPEC_VZERO: ang_f = not_pos(e.h0) ? AngHalf : 16'd0;
			SPEC_HZERO: ang_f = not_pos(e.v0) ? AngNegQuarter : AngQuarter;
			default: begin
				if (not_pos(e.h0)) ang_f = not_pos(e.v0) ? e.ang + AngNegHalf
					: AngHalf - e.ang;
				else if (e.v0[31]) ang_f = 16'd0 - e.ang;
			end
		endcase
	end
	assign mul = $signed(e.h) * $signed({1'b0, gain_of(e.stop)});
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_m <= 1'b0;
		else if (adv) v_m <= e.valid;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			last_m <= e.last; spec_m <= e.spec; ang_s2 <= ang_f;
			mag_pass_s2 <= (e.spec == SPEC_HZERO) ? e.v : e.h;
			prod_s2 <= mul + {32'd0, RoundHalf};
		end
	end

	// output register
	logic [31:0] m32, ms;
	always_comb begin
		m32 = (spec_m == SPEC_NONE) ? prod_s2[47:16] : mag_pass_s2;
		ms = $signed(m32) >>> 12;
		if (!ms[31] && ms > MagSat) ms = MagSat;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (adv) out_valid <= v_m;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			grad_magnitude <= ms[19:0]; grad_angle <= ang_s2; frame_last <= last_m;
		end
	end
endmodule
`default_nettype wire

// ===== dv/gradient_cordic_magnitude_angle_map_tb.sv =====
`timescale 1ns / 1ps
module gradient_cordic_magnitude_angle_map_tb import gcma_pkg::*; ();

	localparam int CycleLimit = 400000;
	localparam int DrainCycles = 60;

	typedef struct packed {
		logic [19:0] mag;
		logic [15:0] ang;
		logic last;
	} grad_t;

	logic clk;
	logic arst_n;
	logic valid;
	logic stall;
	logic [31:0] pixel;
	logic out_valid;
	logic out_stall;
	logic [19:0] grad_magnitude;
	logic [15:0] grad_angle;
	logic frame_last;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	gradient_cordic_magnitude_angle_map u_dut (
		.clk(clk), .arst_n(arst_n), .valid(valid), .stall(stall), .pixel(pixel),
		.out_valid(out_valid), .out_stall(out_stall), .grad_magnitude(grad_magnitude),
		.grad_angle(grad_angle), .frame_last(frame_last), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	logic [31:0] pixel_q[$];
	grad_t grad_expected_q[$];
	logic [31:0] row_store[2 * MaxWidth];
	logic [8:0] width_reg;
	logic [11:0] height_reg;
	int col_pos;
	int row_pos;
	int errors;
	int cycles;
	bit quiet;
	bit taken;
	int in_gap;
	int out_gap;

	// clock and single reset
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic nonpositive(input logic [31:0] v);
		return (v == 32'd0) || v[31];
	endfunction

	function automatic logic [31:0] clip_grad(input logic [31:0] d);
		logic [31:0] c;
		c = d;
		if (d[31]) begin
			if (d < 32'hfff8_0000) c = 32'hfff8_0000;
		end else if (d > 32'h0007_ffff) begin
			c = 32'h0007_ffff;
		end
		return c << 12;
	endfunction

	// vectoring rotation: angle in Q12, gain-corrected magnitude out
	function automatic logic [15:0] vector_angle(input logic [31:0] v0, input logic [31:0] h0,
			output logic [31:0] mag);
		logic [31:0] h, v, vs, hs;
		logic [15:0] ang;
		logic [15:0] atan_k[13];
		longint gain_k[13];
		longint sh;
		logic [63:0] shu;
		int last;
		bit stop;
		atan_k = '{16'd3217, 16'd1899, 16'd1003, 16'd509, 16'd256, 16'd128, 16'd64,
			16'd32, 16'd16, 16'd8, 16'd4, 16'd2, 16'd1};
		gain_k = '{46341, 41449, 40211, 39901, 39823, 39803, 39799,
			39797, 39797, 39797, 39797, 39797, 39797};
		h = nonpositive(h0) ? -h0 : h0;
		v = nonpositive(v0) ? -v0 : v0;
		ang = 16'd0;
		last = 0;
		stop = 1'b0;
		if (v == 32'd0) begin
			mag = h;
			return nonpositive(h0) ? AngHalf : 16'd0;
		end
		if (h == 32'd0) begin
			mag = v;
			return nonpositive(v0) ? AngNegQuarter : AngQuarter;
		end
		for (int i = 0; i < 13; i++) begin
			if (!stop) begin
				vs = $signed(v) >>> i;
				hs = $signed(h) >>> i;
				if (nonpositive(v)) begin
					vs = -vs;
					ang = ang - atan_k[i];
				end else begin
					hs = -hs;
					ang = ang + atan_k[i];
				end
				v = v + hs;
				h = h + vs;
				last = i;
				if (v == 32'd0) stop = 1'b1;
			end
		end
		if (nonpositive(h0)) begin
			if (nonpositive(v0)) ang = ang + AngNegHalf;
			else ang = AngHalf - ang;
		end else if (v0[31]) begin
			ang = -ang;
		end
		sh = longint'($signed(h)) * gain_k[last] + 64'sh8000;
		shu = sh;
		mag = shu[47:16];
		return ang;
	endfunction

	// advance the frame position and work out the gradient of one pixel
	function automatic bit predict_grad(input logic [31:0] cur, output grad_t g);
		int w, hgt, x, r, bc, bp;
		logic [31:0] gh, gv, m;
		logic [15:0] a;
		bit hit;
		w = width_reg;
		hgt = height_reg;
		x = col_pos;
		r = row_pos;
		hit = 1'b0;
		g = '0;
		if (w < 3) w = 3;
		if (w > MaxWidth) w = MaxWidth;
		if (hgt < 3) hgt = 3;
		if (x >= w) x = 0;
		if (r >= hgt) r = 0;
		bc = (r & 1) * MaxWidth;
		bp = ((r + 1) & 1) * MaxWidth;
		if (r >= 2 && x >= 1 && x + 2 <= w) begin
			gh = clip_grad(row_store[bp + x + 1] - row_store[bp + x - 1]);
			gv = clip_grad(cur - row_store[bc + x]);
			a = vector_angle(gv, gh, m);
			m = $signed(m) >>> 12;
			if (!m[31] && m > 32'h0003_ffff) m = 32'h0003_ffff;
			g.mag = m[19:0];
			g.ang = a;
			g.last = (x + 2 == w) && (r + 1 == hgt);
			hit = 1'b1;
		end
		row_store[bc + x] = cur;
		x++;
		if (x >= w) begin
			x = 0;
			r++;
			if (r >= hgt) r = 0;
		end
		col_pos = x;
		row_pos = r;
		return hit;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// drive pixels, with random gaps between transactions unless quiet is set
	always @(negedge clk) begin
		if (arst_n) begin
			if (!valid || taken) begin
				if (in_gap > 0) begin
					valid <= 1'b0;
					in_gap--;
				end else if (!quiet && $urandom_range(0, 7) == 0) begin
					valid <= 1'b0;
					in_gap = $urandom_range(0, 3);
				end else if (pixel_q.size() > 0) begin
					pixel <= pixel_q.pop_front();
					valid <= 1'b1;
				end else begin
					valid <= 1'b0;
				end
			end
			// result back-pressure in bursts unless quiet is set
			if (out_gap > 0) begin
				out_stall <= 1'b1;
				out_gap--;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				out_gap = $urandom_range(0, 3);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// predict on accepted pixels, check accepted results
	always @(posedge clk) begin
		grad_t g;
		grad_t want;
		if (arst_n) begin
			taken <= valid && !stall;
			if (valid && !stall) begin
				if (predict_grad(pixel, g)) grad_expected_q.push_back(g);
			end
			if (out_valid && !out_stall) begin
				if (grad_expected_q.size() == 0) begin
					report_mismatch("unexpected result transaction", 32'd1, 32'd0);
				end else begin
					want = grad_expected_q.pop_front();
					if (grad_magnitude !== want.mag)
						report_mismatch("grad_magnitude", 32'(grad_magnitude), 32'(want.mag));
					if (grad_angle !== want.ang)
						report_mismatch("grad_angle", 32'(grad_angle), 32'(want.ang));
					if (frame_last !== want.last)
						report_mismatch("frame_last", 32'(frame_last), 32'(want.last));
				end
			end
		end
	end

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic reg_write(input logic [3:0] addr, input logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= addr[2:0];
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (addr == RegWidth) width_reg = data[8:0];
		else height_reg = data[11:0];
		col_pos = 0;
		row_pos = 0;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// hold until every pixel is in and every result is out
	task automatic drain();
		do @(posedge clk); while (pixel_q.size() > 0 || valid);
		while (grad_expected_q.size() > 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	function automatic logic [31:0] random_pixel();
		logic [31:0] corner[6];
		corner = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff, 32'h0000_0005,
			32'h0008_0000};
		case ($urandom_range(0, 9))
			0, 1, 2: return $urandom;
			3, 4: return corner[$urandom_range(0, 5)];
			5: return 32'($urandom_range(0, 8)) - 32'd4;
			default: return 32'($urandom_range(0, 4000)) - 32'd2000;
		endcase
	endfunction

	task automatic run_frame(input int w, input int hgt, input int count, input bit no_idle);
		drain();
		quiet = no_idle;
		reg_write(RegWidth, 32'(w));
		reg_write(RegHeight, 32'(hgt));
		repeat (count) pixel_q.push_back(random_pixel());
	endtask

	initial begin
		logic [31:0] directed[18];
		arst_n = 1'b0;
		valid = 1'b0;
		pixel = '0;
		out_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		width_reg = 9'd256;
		height_reg = 12'd256;
		col_pos = 0;
		row_pos = 0;
		errors = 0;
		cycles = 0;
		quiet = 1'b0;
		taken = 1'b0;
		in_gap = 0;
		out_gap = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed 3x3 frames: extremes, zero verticals and horizontals, wrapping
		directed = '{
			32'h7fff_ffff, 32'h0000_0000, 32'h8000_0000,
			32'h0000_0010, 32'h1234_5678, 32'h0000_0010,
			32'h8000_0000, 32'hffff_ffff, 32'h7fff_ffff,
			32'h0000_0003, 32'h0000_0009, 32'h0000_0003,
			32'h0000_0100, 32'h0000_0009, 32'hffff_ff00,
			32'h0000_0000, 32'h0000_0009, 32'h0000_0000};
		drain();
		reg_write(RegWidth, 32'd3);
		reg_write(RegHeight, 32'd3);
		foreach (directed[i]) pixel_q.push_back(directed[i]);

		// random frames across the register range, out-of-range values included
		run_frame(4, 5, 200, 1'b0);
		run_frame(256, 3, 800, 1'b0);
		run_frame(0, 0, 60, 1'b0);
		run_frame(511, 4095, 300, 1'b0);
		run_frame(17, 4095, 150, 1'b0);
		run_frame(10, 7, 173, 1'b0);
		run_frame(3, 4095, 60, 1'b0);
		run_frame(9, 2, 55, 1'b1);
		run_frame(6, 4, 48, 1'b1);

		drain();
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
